// ===== rtl/ssm_pkg.sv =====
// ----------------------------------------------------------------------------
// ssm_pkg
// shared constants and controller/datapath interface types for the merge
// ----------------------------------------------------------------------------
package ssm_pkg;

    localparam int VALUE_W     = 32;
    localparam int MAX_LEN_DEF = 16;

    // tuser bit positions, lowest bit first
    localparam int S_USER_SEL  = 0;
    localparam int S_USER_END  = 1;
    localparam int S_USER_W    = 2;
    localparam int M_USER_SRC  = 0;
    localparam int M_USER_DROP = 1;
    localparam int M_USER_W    = 2;

    localparam logic LIST_A = 1'b0;
    localparam logic LIST_B = 1'b1;

    typedef struct packed {
        logic take;
        logic decide;
    } t_ssm_cmd;

    typedef struct packed {
        logic drop;
        logic pop_any;
    } t_ssm_sts;

endpackage

// ===== rtl/sorted_stream_merge.sv =====
// ----------------------------------------------------------------------------
// sorted_stream_merge
// merges two ascending signed lists into one ascending stream
// ----------------------------------------------------------------------------
// Words of lists A and B arrive in any interleaving and wait in a ram buffer
// of MAX_LEN words per list. After each accepted word the block emits every
// merged word then due, A's head only when strictly smaller so B goes first
// on a tie, and takes no new word until that run is done. Each merged word
// passes a head compare, then an output hand-over that waits for tready; a
// run without a drop first waits out the registered read of each buffer
// ram, and a dropped word is reported before any merged word.
// The final merged word carries tlast and the block then re-arms. A word for
// a full buffer or for a list that has already ended is returned with the
// dropped flag set; its end mark still ends its list.
module sorted_stream_merge
    import ssm_pkg::*;
#(
    parameter int MAX_LEN = MAX_LEN_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [VALUE_W-1:0]  s_axis_tdata,  // value
    input  logic [S_USER_W-1:0] s_axis_tuser,  // list_select, end_only
    input  logic                s_axis_tlast,  // is_last
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [VALUE_W-1:0]  m_axis_tdata,  // merged_value
    output logic [M_USER_W-1:0] m_axis_tuser,  // from_list, dropped
    output logic                m_axis_tlast   // merge_done
);

    t_ssm_cmd cmd;
    t_ssm_sts sts;
    logic     out_src, out_drop;

    ssm_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (s_axis_tvalid),
        .i_m_ready (m_axis_tready),
        .i_sts     (sts),
        .o_cmd     (cmd),
        .o_s_ready (s_axis_tready),
        .o_m_valid (m_axis_tvalid)
    );

    ssm_dp #(.MAX_LEN(MAX_LEN)) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .i_value    (s_axis_tdata),
        .i_sel      (s_axis_tuser[S_USER_SEL]),
        .i_last     (s_axis_tlast),
        .i_end_only (s_axis_tuser[S_USER_END]),
        .o_value    (m_axis_tdata),
        .o_src      (out_src),
        .o_done     (m_axis_tlast),
        .o_drop     (out_drop)
    );

    always_comb begin
        m_axis_tuser              = '0;
        m_axis_tuser[M_USER_SRC]  = out_src;
        m_axis_tuser[M_USER_DROP] = out_drop;
    end

endmodule

// ===== rtl/ssm_ram.sv =====
// ----------------------------------------------------------------------------
// ssm_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module ssm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/ssm_ctrl.sv =====
// ----------------------------------------------------------------------------
// ssm_ctrl
// sequencer: takes one word, reports any drop, then pops heads until none is due
// ----------------------------------------------------------------------------
module ssm_ctrl
    import ssm_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_s_valid,
    input  logic     i_m_ready,
    input  t_ssm_sts i_sts,
    output t_ssm_cmd o_cmd,
    output logic     o_s_ready,
    output logic     o_m_valid
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DROP,
        S_READ,
        S_DECIDE,
        S_EMIT
    } t_state;

    t_state r_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_s_valid) begin
                        r_state <= i_sts.drop ? S_DROP : S_READ;
                    end
                end
                S_DROP: begin
                    if (i_m_ready) begin
                        r_state <= S_DECIDE;
                    end
                end
                S_READ: begin
                    r_state <= S_DECIDE;
                end
                S_DECIDE: begin
                    r_state <= i_sts.pop_any ? S_EMIT : S_IDLE;
                end
                S_EMIT: begin
                    if (i_m_ready) begin
                        r_state <= S_DECIDE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_s_ready     = (r_state == S_IDLE);
    assign o_m_valid     = (r_state == S_DROP) || (r_state == S_EMIT);
    assign o_cmd.take    = (r_state == S_IDLE) && i_s_valid;
    assign o_cmd.decide  = (r_state == S_DECIDE);

endmodule

// ===== rtl/ssm_dp.sv =====
// ----------------------------------------------------------------------------
// ssm_dp
// list buffers, fill and index counters, head compare and output register
// ----------------------------------------------------------------------------
module ssm_dp
    import ssm_pkg::*;
#(
    parameter int MAX_LEN = MAX_LEN_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_ssm_cmd           i_cmd,
    output t_ssm_sts           o_sts,
    input  logic [VALUE_W-1:0] i_value,
    input  logic               i_sel,
    input  logic               i_last,
    input  logic               i_end_only,
    output logic [VALUE_W-1:0] o_value,
    output logic               o_src,
    output logic               o_done,
    output logic               o_drop
);

    localparam int IDX_W  = $clog2(MAX_LEN);
    localparam int FILL_W = $clog2(MAX_LEN + 1);

    logic [IDX_W-1:0]   r_rd_a, r_wr_a, r_rd_b, r_wr_b;
    logic [FILL_W-1:0]  r_fill_a, r_fill_b;
    logic               r_ended_a, r_ended_b;
    logic [VALUE_W-1:0] r_out_value;
    logic               r_out_src, r_out_done, r_out_drop;

    logic [VALUE_W-1:0] head_a, head_b;
    logic               full_a, full_b, empty_a, empty_b;
    logic               drop, we_a, we_b, pop_a, pop_b;
    logic               n_ended_a, n_ended_b;

    function automatic logic [IDX_W-1:0] next_idx(input logic [IDX_W-1:0] idx);
        return (idx == IDX_W'(MAX_LEN - 1)) ? '0 : idx + 1'b1;
    endfunction

    ssm_ram #(.WIDTH(VALUE_W), .DEPTH(MAX_LEN)) u_ram_a (
        .i_clk   (i_clk),
        .i_we    (we_a),
        .i_waddr (r_wr_a),
        .i_wdata (i_value),
        .i_raddr (r_rd_a),
        .o_rdata (head_a)
    );

    ssm_ram #(.WIDTH(VALUE_W), .DEPTH(MAX_LEN)) u_ram_b (
        .i_clk   (i_clk),
        .i_we    (we_b),
        .i_waddr (r_wr_b),
        .i_wdata (i_value),
        .i_raddr (r_rd_b),
        .o_rdata (head_b)
    );

    assign full_a  = (r_fill_a == FILL_W'(MAX_LEN));
    assign full_b  = (r_fill_b == FILL_W'(MAX_LEN));
    assign empty_a = (r_fill_a == '0);
    assign empty_b = (r_fill_b == '0);

    assign drop = !i_end_only && ((i_sel == LIST_B) ? (r_ended_b || full_b)
                                                    : (r_ended_a || full_a));
    assign we_a = i_cmd.take && !i_end_only && !drop && (i_sel == LIST_A);
    assign we_b = i_cmd.take && !i_end_only && !drop && (i_sel == LIST_B);

    always_comb begin
        pop_a = 1'b0;
        pop_b = 1'b0;
        if (!empty_a && !empty_b) begin
            if ($signed(head_a) < $signed(head_b)) begin
                pop_a = 1'b1;
            end else begin
                pop_b = 1'b1;
            end
        end else if (!empty_a && r_ended_b) begin
            pop_a = 1'b1;
        end else if (!empty_b && r_ended_a) begin
            pop_b = 1'b1;
        end
    end

    always_comb begin
        n_ended_a = r_ended_a;
        n_ended_b = r_ended_b;
        if (i_end_only || i_last) begin
            if (i_sel == LIST_B) begin
                n_ended_b = 1'b1;
            end else begin
                n_ended_a = 1'b1;
            end
        end
    end

    assign o_sts.drop    = drop;
    assign o_sts.pop_any = pop_a || pop_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_a     <= '0;
            r_wr_a     <= '0;
            r_rd_b     <= '0;
            r_wr_b     <= '0;
            r_fill_a   <= '0;
            r_fill_b   <= '0;
            r_ended_a  <= 1'b0;
            r_ended_b  <= 1'b0;
            r_out_drop <= 1'b0;
        end else if (i_cmd.take) begin
            r_ended_a <= n_ended_a;
            r_ended_b <= n_ended_b;
            if (we_a) begin
                r_wr_a   <= next_idx(r_wr_a);
                r_fill_a <= r_fill_a + 1'b1;
            end
            if (we_b) begin
                r_wr_b   <= next_idx(r_wr_b);
                r_fill_b <= r_fill_b + 1'b1;
            end
            if (drop) begin
                r_out_drop <= 1'b1;
            end
        end else if (i_cmd.decide) begin
            if (pop_a) begin
                r_rd_a     <= next_idx(r_rd_a);
                r_fill_a   <= r_fill_a - 1'b1;
                r_out_drop <= 1'b0;
            end else if (pop_b) begin
                r_rd_b     <= next_idx(r_rd_b);
                r_fill_b   <= r_fill_b - 1'b1;
                r_out_drop <= 1'b0;
            end else if (r_ended_a && r_ended_b && empty_a && empty_b) begin
                r_ended_a <= 1'b0;
                r_ended_b <= 1'b0;
            end
        end
    end

    // output word payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.take && drop) begin
            r_out_value <= i_value;
            r_out_src   <= i_sel;
            r_out_done  <= 1'b0;
        end else if (i_cmd.decide && pop_a) begin
            r_out_value <= head_a;
            r_out_src   <= LIST_A;
            r_out_done  <= r_ended_a && r_ended_b && empty_b
                           && (r_fill_a == FILL_W'(1));
        end else if (i_cmd.decide && pop_b) begin
            r_out_value <= head_b;
            r_out_src   <= LIST_B;
            r_out_done  <= r_ended_a && r_ended_b && empty_a
                           && (r_fill_b == FILL_W'(1));
        end
    end

    assign o_value = r_out_value;
    assign o_src   = r_out_src;
    assign o_done  = r_out_done;
    assign o_drop  = r_out_drop;

    a_fill_a_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill_a <= FILL_W'(MAX_LEN))
        else $error("list a fill above capacity");

    a_fill_b_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill_b <= FILL_W'(MAX_LEN))
        else $error("list b fill above capacity");

    a_one_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(pop_a && pop_b))
        else $error("both heads popped at once");

    a_pop_clears_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.decide && (pop_a || pop_b)) |=> !r_out_drop)
        else $error("merged word flagged as dropped");

endmodule
